/* rtl/length_prefixed_frame_deframer_top_defines.svh */
// assertion macros shared by the deframer modules
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_TOP_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define LPFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies expression in the next
`define LPFD_ASSERT_NEXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

/* rtl/lpfd_pkg.sv */
package lpfd_pkg;

  // number of peer streams
  localparam int PEER_SLOTS = 8;
  // width of the slot field on the ports
  localparam int SLOT_W = 3;
  // bits that index the per-peer state
  localparam int SLOT_IW = (PEER_SLOTS > 8) ? SLOT_W :
                           ((PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1);

  // header layout
  localparam int HDR_BYTES  = 8;
  localparam int WORD_BYTES = 4;
  localparam int HDR_KEEP   = HDR_BYTES - 1;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // stream widths
  localparam int TDATA_W = 16;

  // configuration port
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_MAGIC = 1'b0;

  // one queued byte
  typedef struct packed {
    logic [SLOT_IW-1:0] slot;
    logic [7:0]         data;
    logic               chunk_end;
  } item_t;

endpackage

/* rtl/lpfd_front.sv */
`include "length_prefixed_frame_deframer_top_defines.svh"

module lpfd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpfd_pkg::SLOT_W-1:0]   peer_slot,
  input  logic [7:0]                    data_byte,
  input  logic                          chunk_end,
  output logic                          q_valid,
  output lpfd_pkg::item_t               q_item,
  input  logic                          pop
);
  import lpfd_pkg::*;

  item_t              entry [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [QCNT_W-1:0]  count_next;
  logic               in_range;
  logic               push;

  // bytes for slots beyond the last peer are taken and dropped here
  assign in_range = (int'(peer_slot) < PEER_SLOTS);
  assign in_ready = (count != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready && in_range;

  assign q_valid = (count != '0);
  assign q_item  = entry[rd_ptr];

  // occupancy
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + QCNT_W'(1);
    end else if (pop && !push) begin
      count_next = count - QCNT_W'(1);
    end
  end

  // queue pointers and storage
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (int'(wr_ptr) == QDEPTH - 1) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (int'(rd_ptr) == QDEPTH - 1) ? '0 : rd_ptr + QPTR_W'(1);
      end
    end
    if (push) begin
      entry[wr_ptr] <= '{slot: peer_slot[SLOT_IW-1:0], data: data_byte,
                         chunk_end: chunk_end};
    end
  end

  `LPFD_ASSERT(a_count_bound, count <= QCNT_W'(QDEPTH), "queue count above depth")
  `LPFD_ASSERT(a_pop_nonempty, !pop || (count != '0), "pop from empty queue")

endmodule

/* rtl/lpfd_back.sv */
`include "length_prefixed_frame_deframer_top_defines.svh"

module lpfd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [31:0]                   frame_magic,
  input  logic                          q_valid,
  input  lpfd_pkg::item_t               q_item,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lpfd_pkg::SLOT_W-1:0]   out_slot,
  output logic [7:0]                    out_byte,
  output logic                          out_last,
  output logic                          out_empty
);
  import lpfd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  // per-peer parser state
  phase_t                     phase [PEER_SLOTS];
  logic [2:0]                 hcnt  [PEER_SLOTS];
  logic [HDR_KEEP-1:0][7:0]   hdr   [PEER_SLOTS];
  logic [31:0]                rem   [PEER_SLOTS];

  logic [SLOT_IW-1:0]         idx;
  phase_t                     cur_phase;
  logic [2:0]                 cur_hcnt;
  logic [HDR_KEEP-1:0][7:0]   cur_hdr;
  logic [31:0]                cur_rem;
  logic [31:0]                rem_dec;
  logic [31:0]                magic;
  logic [31:0]                len;

  phase_t                     phase_next;
  logic [2:0]                 hcnt_next;
  logic [31:0]                rem_next;
  logic                       hdr_wr;
  logic                       res_valid;
  logic                       res_last;
  logic                       res_empty;
  logic [7:0]                 res_byte;
  logic                       out_space;

  assign idx       = q_item.slot;
  assign cur_phase = phase[idx];
  assign cur_hcnt  = hcnt[idx];
  assign cur_hdr   = hdr[idx];
  assign cur_rem   = rem[idx];
  assign rem_dec   = (cur_rem != '0) ? cur_rem - 32'd1 : '0;
  assign magic     = cur_hdr[WORD_BYTES-1:0];
  assign len       = {q_item.data, cur_hdr[HDR_KEEP-1:WORD_BYTES]};

  // one byte a cycle while the output register can take a result
  assign out_space = !out_valid || out_ready;
  assign pop       = q_valid && out_space;

  // next state of the addressed slot and its result
  always_comb begin
    phase_next = cur_phase;
    hcnt_next  = cur_hcnt;
    rem_next   = cur_rem;
    hdr_wr     = 1'b0;
    res_valid  = 1'b0;
    res_last   = 1'b0;
    res_empty  = 1'b0;
    res_byte   = q_item.data;
    case (cur_phase)
      PH_DISCARD: begin
        if (q_item.chunk_end) begin
          phase_next = PH_HEADER;
          hcnt_next  = '0;
        end
      end
      PH_PAYLOAD: begin
        rem_next  = rem_dec;
        res_valid = 1'b1;
        if (rem_dec == '0) begin
          phase_next = PH_HEADER;
          hcnt_next  = '0;
          res_last   = 1'b1;
        end
      end
      default: begin
        // header phase, unused code behaves the same
        if (int'(cur_hcnt) < HDR_KEEP) begin
          hdr_wr    = 1'b1;
          hcnt_next = cur_hcnt + 3'd1;
        end else begin
          hcnt_next = '0;
          if (magic != frame_magic) begin
            phase_next = q_item.chunk_end ? PH_HEADER : PH_DISCARD;
          end else if (len == '0) begin
            phase_next = PH_HEADER;
            rem_next   = '0;
            res_valid  = 1'b1;
            res_last   = 1'b1;
            res_empty  = 1'b1;
            res_byte   = '0;
          end else begin
            phase_next = PH_PAYLOAD;
            rem_next   = len;
          end
        end
      end
    endcase
  end

  // slot state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < PEER_SLOTS; s++) begin
        phase[s] <= PH_HEADER;
        hcnt[s]  <= '0;
        rem[s]   <= '0;
      end
    end else if (pop) begin
      phase[idx] <= phase_next;
      hcnt[idx]  <= hcnt_next;
      rem[idx]   <= rem_next;
    end
    if (pop && hdr_wr) begin
      hdr[idx][cur_hcnt] <= q_item.data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (pop && res_valid) begin
      out_slot  <= SLOT_W'(idx);
      out_byte  <= res_byte;
      out_last  <= res_last;
      out_empty <= res_empty;
    end
  end

  `LPFD_ASSERT(a_empty_form, !(out_valid && out_empty) || (out_last && out_byte == 8'd0), "empty frame result malformed")
  `LPFD_ASSERT_NEXT(a_result_loaded, pop && res_valid, out_valid, "result not presented")

endmodule

/* rtl/length_prefixed_frame_deframer_top.sv */
// Per-peer deframer for magic/length prefixed frames. Each input beat carries one byte
// for one of up to eight peers; every peer keeps its own parse state. A frame is an
// 8-byte header (32-bit magic, 32-bit length, little-endian) and its payload; each
// payload byte leaves as one output beat with tlast on the final one, and a zero-length
// frame gives one beat with tuser set and tdata byte zero. A wrong magic drops the rest
// of that chunk silently. Other header bytes produce no output. The block takes one byte per
// clock sustained while the output is not stalled: the per-peer state is read, updated and
// written back in the same cycle of the back end, behind a 4-entry queue. A result is
// registered and presented in the cycle after its byte is taken from the queue; a stalled
// output holds the back end, and the queue fills before the input stalls.
// Write frame_magic at address 0 only while the stream is idle.
module length_prefixed_frame_deframer_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [2:0] peer_slot, [10:3] data_byte, [15:11] zero
  input  logic [lpfd_pkg::TDATA_W-1:0]  s_axis_tdata,
  // chunk_end
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] out_slot, [10:3] payload_byte, [15:11] zero
  output logic [lpfd_pkg::TDATA_W-1:0]  m_axis_tdata,
  // frame_last
  output logic                          m_axis_tlast,
  // [0] frame_empty
  output logic [0:0]                    m_axis_tuser,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpfd_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lpfd_pkg::*;

  logic [31:0]          frame_magic;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 q_valid;
  item_t                q_item;
  logic                 pop;
  logic [SLOT_W-1:0]    out_slot;
  logic [7:0]           out_byte;
  logic                 out_empty;

  // configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign prdata  = (reg_idx == REG_FRAME_MAGIC) ? frame_magic : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic <= '0;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_FRAME_MAGIC) begin
      frame_magic <= pwdata;
    end
  end

  // input side and queue
  lpfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .peer_slot (s_axis_tdata[SLOT_W-1:0]),
    .data_byte (s_axis_tdata[SLOT_W+7:SLOT_W]),
    .chunk_end (s_axis_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // parser and output register
  lpfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_magic (frame_magic),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .pop         (pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_slot    (out_slot),
    .out_byte    (out_byte),
    .out_last    (m_axis_tlast),
    .out_empty   (out_empty)
  );

  // output beat packing
  assign m_axis_tdata = {(TDATA_W - SLOT_W - 8)'(0), out_byte, out_slot};
  assign m_axis_tuser = out_empty;

endmodule

/* test/length_prefixed_frame_deframer_top_test.sv */
module length_prefixed_frame_deframer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lpfd_pkg::*;

  // register map and run sizing
  localparam logic [ADDR_W-1:0] ADDR_FRAME_MAGIC = ADDR_W'(4 * REG_FRAME_MAGIC);
  localparam logic [ADDR_W-1:0] ADDR_UNMAPPED    = ADDR_W'(4 * (REG_FRAME_MAGIC + 1));
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_LIMIT     = 4000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int LIMIT_CYCLES    = 200000;
  localparam int NUM_PHASES      = 4;
  localparam int unsigned SEND_IDLE_PCT [NUM_PHASES] = '{0, 60, 0, 37};
  localparam int unsigned RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 60, 37};

  // per-slot parse mode
  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_BODY = 2'd1,
    PH_DROP = 2'd2
  } rx_phase_t;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {
    BY_PREDICTOR,
    TYPED_EMPTY,
    TYPED_LAST
  } exp_kind_t;

  // one output beat
  typedef struct packed {
    logic [2:0] slot;
    logic [7:0] data;
    logic       last;
    logic       empty;
  } beat_t;

  typedef struct {
    logic [2:0] slot;
    logic [7:0] data;
    logic       ce;
    exp_kind_t  how;
  } dir_row_t;

  localparam int DIR_ROWS = 26;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // [2:0] peer_slot, [10:3] data_byte, [15:11] zero
  logic [TDATA_W-1:0]  s_axis_tdata;
  // chunk_end
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [2:0] out_slot, [10:3] payload_byte, [15:11] zero
  logic [TDATA_W-1:0]  m_axis_tdata;
  // frame_last
  logic                m_axis_tlast;
  // [0] frame_empty
  logic [0:0]          m_axis_tuser;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  // predictor state
  logic [31:0] magic_reg;
  rx_phase_t   slot_mode [PEER_SLOTS];
  logic [2:0]  hdr_cnt [PEER_SLOTS];
  logic [55:0] hdr_buf [PEER_SLOTS];
  logic [31:0] body_left [PEER_SLOTS];

  // expected output beats, oldest first
  beat_t pending_beats [$];
  // bytes queued for each slot, {chunk_end, byte}
  logic [8:0] slot_backlog [PEER_SLOTS][$];

  int unsigned send_idle = 0;
  int unsigned recv_stall = 0;
  int cycles = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int beats_seen = 0;
  int ends_seen = 0;
  int empties_seen = 0;

  // directed stimulus: empty frame on slot 0 with chunk marks inside its header,
  // one-byte frame on slot 7, bad magic on slot 3 dropped up to its chunk end
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{3'd0, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd3, 8'hFF, 1'b0, BY_PREDICTOR},
    '{3'd7, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd0, 8'h00, 1'b1, BY_PREDICTOR},
    '{3'd3, 8'hFF, 1'b0, BY_PREDICTOR},
    '{3'd7, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd0, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd3, 8'hFF, 1'b0, BY_PREDICTOR},
    '{3'd7, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd0, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd3, 8'hFF, 1'b0, BY_PREDICTOR},
    '{3'd7, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd0, 8'h00, 1'b1, BY_PREDICTOR},
    '{3'd3, 8'hFF, 1'b0, BY_PREDICTOR},
    '{3'd7, 8'h01, 1'b0, BY_PREDICTOR},
    '{3'd0, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd3, 8'hFF, 1'b0, BY_PREDICTOR},
    '{3'd7, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd0, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd3, 8'hFF, 1'b0, BY_PREDICTOR},
    '{3'd7, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd0, 8'h00, 1'b0, TYPED_EMPTY},
    '{3'd3, 8'hFF, 1'b0, BY_PREDICTOR},
    '{3'd7, 8'h00, 1'b0, BY_PREDICTOR},
    '{3'd3, 8'hAA, 1'b1, BY_PREDICTOR},
    '{3'd7, 8'hFF, 1'b1, TYPED_LAST}
  };

  length_prefixed_frame_deframer_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycles,
               pending_beats.size());
      $display("[length_prefixed_frame_deframer_top] ERROR");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 30)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    mismatches++;
  endtask

  // one byte through the per-slot parser; returns 1 when it yields a beat
  function automatic bit deframe_byte(input logic [2:0] slot, input logic [7:0] data,
                                      input logic ce, output beat_t res);
    int s;
    logic [31:0] len;
    res = '0;
    if (slot >= PEER_SLOTS)
      return 1'b0;
    s = int'(slot);
    case (slot_mode[s])
      PH_DROP: begin
        if (ce) begin
          slot_mode[s] = PH_HEAD;
          hdr_cnt[s] = '0;
        end
        return 1'b0;
      end
      PH_BODY: begin
        if (body_left[s] != 0)
          body_left[s] = body_left[s] - 32'd1;
        res = '{slot: slot, data: data, last: 1'b0, empty: 1'b0};
        if (body_left[s] == 0) begin
          slot_mode[s] = PH_HEAD;
          hdr_cnt[s] = '0;
          res.last = 1'b1;
        end
        return 1'b1;
      end
      default: begin
        // first seven header bytes are only stored
        if (hdr_cnt[s] < HDR_BYTES - 1) begin
          hdr_buf[s][8*hdr_cnt[s] +: 8] = data;
          hdr_cnt[s] = hdr_cnt[s] + 3'd1;
          return 1'b0;
        end
        len = {data, hdr_buf[s][55:32]};
        hdr_cnt[s] = '0;
        if (hdr_buf[s][31:0] != magic_reg) begin
          slot_mode[s] = ce ? PH_HEAD : PH_DROP;
          return 1'b0;
        end
        if (len == 0) begin
          slot_mode[s] = PH_HEAD;
          body_left[s] = '0;
          res = '{slot: slot, data: 8'h00, last: 1'b1, empty: 1'b1};
          return 1'b1;
        end
        slot_mode[s] = PH_BODY;
        body_left[s] = len;
        return 1'b0;
      end
    endcase
  endfunction

  // present one byte, wait for the beat to be taken, then predict
  task automatic send_byte(input logic [2:0] slot, input logic [7:0] data, input logic ce,
                           input exp_kind_t how);
    beat_t got;
    bit has;
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= TDATA_W'({data, slot});
    s_axis_tlast <= ce;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    has = deframe_byte(slot, data, ce, got);
    case (how)
      TYPED_EMPTY: begin
        got = '{slot: slot, data: 8'h00, last: 1'b1, empty: 1'b1};
        has = 1'b1;
      end
      TYPED_LAST: begin
        got = '{slot: slot, data: data, last: 1'b1, empty: 1'b0};
        has = 1'b1;
      end
      default: begin
      end
    endcase
    if (has)
      pending_beats.insert(pending_beats.size(), got);
  endtask

  task automatic queue_byte(input int s, input logic [7:0] b, input logic ce);
    slot_backlog[s].insert(slot_backlog[s].size(), {ce, b});
  endtask

  // next sequence for a slot, picked from where its parser stands now
  task automatic refill_slot(input int s);
    int r, n, k;
    logic [31:0] word, len;
    logic [7:0] b;
    case (slot_mode[s])
      PH_DROP: begin
        n = $urandom_range(2);
        repeat (n) queue_byte(s, 8'($urandom_range(255)), 1'b0);
        queue_byte(s, 8'($urandom_range(255)), 1'b1);
      end
      PH_BODY: begin
        n = (body_left[s] > 16) ? 16 : body_left[s];
        repeat (n) queue_byte(s, 8'($urandom_range(255)), $urandom_range(3) == 0);
      end
      default: begin
        if (hdr_cnt[s] != 0) begin
          // finish a broken header so that it fails the magic check on a chunk end
          for (k = int'(hdr_cnt[s]); k < HDR_BYTES; k++) begin
            b = 8'($urandom_range(255));
            if (k == WORD_BYTES - 1 && b == magic_reg[31:24])
              b = ~b;
            queue_byte(s, b, k == HDR_BYTES - 1);
          end
        end else begin
          r = $urandom_range(99);
          if (r < 70) begin
            // well-formed frame, short payloads mostly
            word = magic_reg;
            r = $urandom_range(99);
            len = (r < 15) ? 32'd0 : (r < 95) ? $urandom_range(6, 1) : $urandom_range(24, 7);
            for (k = 0; k < WORD_BYTES; k++)
              queue_byte(s, word[8*k +: 8], $urandom_range(3) == 0);
            for (k = 0; k < WORD_BYTES; k++)
              queue_byte(s, len[8*k +: 8], $urandom_range(3) == 0);
            repeat (len) queue_byte(s, 8'($urandom_range(255)), $urandom_range(3) == 0);
          end else if (r < 85) begin
            // one magic bit off, random length, rest of the chunk after it
            word = magic_reg ^ (32'd1 << $urandom_range(31));
            len = $urandom;
            for (k = 0; k < WORD_BYTES; k++)
              queue_byte(s, word[8*k +: 8], $urandom_range(4) == 0);
            for (k = 0; k < WORD_BYTES - 1; k++)
              queue_byte(s, len[8*k +: 8], $urandom_range(4) == 0);
            if ($urandom_range(99) < 40) begin
              queue_byte(s, len[31:24], 1'b1);
            end else begin
              queue_byte(s, len[31:24], 1'b0);
              n = $urandom_range(3);
              repeat (n) queue_byte(s, 8'($urandom_range(255)), 1'b0);
              queue_byte(s, 8'($urandom_range(255)), 1'b1);
            end
          end else begin
            // noise
            n = $urandom_range(6, 1);
            repeat (n) queue_byte(s, 8'($urandom_range(255)), $urandom_range(3) == 0);
          end
        end
      end
    endcase
  endtask

  // stop sending and let every expected beat arrive
  task automatic drain();
    int waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_beats.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_FRAME_MAGIC)
      magic_reg = data;
  endtask

  task automatic apb_read(input logic [ADDR_W-1:0] addr, output logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // output beat check against the oldest expectation
  always @(posedge clk) begin : beat_check
    beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      if (pending_beats.size() == 0) begin
        report_mismatch("beat with nothing expected, tdata", 32'(m_axis_tdata), '0);
      end else begin
        want = pending_beats.pop_front();
        if (m_axis_tdata[2:0] !== want.slot)
          report_mismatch("out_slot", 32'(m_axis_tdata[2:0]), 32'(want.slot));
        if (m_axis_tdata[10:3] !== want.data)
          report_mismatch("payload_byte", 32'(m_axis_tdata[10:3]), 32'(want.data));
        if (m_axis_tdata[TDATA_W-1:11] !== '0)
          report_mismatch("tdata padding", 32'(m_axis_tdata[TDATA_W-1:11]), '0);
        if (m_axis_tlast !== want.last)
          report_mismatch("frame_last", 32'(m_axis_tlast), 32'(want.last));
        if (m_axis_tuser[0] !== want.empty)
          report_mismatch("frame_empty", 32'(m_axis_tuser[0]), 32'(want.empty));
        if (want.last)
          ends_seen++;
        if (want.empty)
          empties_seen++;
      end
    end
  end

  initial begin
    logic [31:0] rd, magic_val;
    logic [8:0] nxt;
    int p, k, s;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    magic_reg = '0;
    for (k = 0; k < PEER_SLOTS; k++) begin
      slot_mode[k] = PH_HEAD;
      hdr_cnt[k] = '0;
      body_left[k] = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows with the reset magic of zero
    for (k = 0; k < DIR_ROWS; k++)
      send_byte(dir_rows[k].slot, dir_rows[k].data, dir_rows[k].ce, dir_rows[k].how);
    drain();

    // random phases, each with its own magic and idle/stall mix
    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       magic_val = 32'hFFFF_FFFF;
        2:       magic_val = 32'h0000_0000;
        default: magic_val = $urandom;
      endcase
      apb_write(ADDR_FRAME_MAGIC, magic_val);
      if (p == 1)
        apb_write(ADDR_UNMAPPED, ~magic_val);
      apb_read(ADDR_FRAME_MAGIC, rd);
      if (rd !== magic_val)
        report_mismatch("frame_magic readback", rd, magic_val);
      send_idle = SEND_IDLE_PCT[p];
      recv_stall = RECV_STALL_PCT[p];
      for (k = 0; k < ITEMS_PER_PHASE; k++) begin
        s = $urandom_range(PEER_SLOTS - 1);
        if (slot_backlog[s].size() == 0)
          refill_slot(s);
        nxt = slot_backlog[s].pop_front();
        send_byte(s[2:0], nxt[7:0], nxt[8], BY_PREDICTOR);
      end
      drain();
    end

    if (pending_beats.size() != 0)
      report_mismatch("beats never delivered", pending_beats.size(), 0);
    $display("sent %0d bytes over %0d slots, checked %0d beats (%0d frame ends, %0d empty)",
             bytes_sent, PEER_SLOTS, beats_seen, ends_seen, empties_seen);
    $display("magic all-ones, all-zero and random, idle/stall mixes up to 60 pct, %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("[length_prefixed_frame_deframer_top] OK");
    else
      $display("[length_prefixed_frame_deframer_top] ERROR");
    $finish;
  end

endmodule
